### src/adcti_pkg.sv
// Shared types, constants and the thermistor code ROM for the ADC table interpolator.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package adcti_pkg;

  localparam int CODE_W    = 12;
  localparam int TEMP_W    = 14;
  localparam int FRAC_BITS = 8;
  localparam int TABLE_ENTRIES = 41;
  localparam int ROM_SIZE  = 41;

  // entries actually used, and the number of segments between them
  localparam int USED      = (TABLE_ENTRIES < ROM_SIZE) ? TABLE_ENTRIES : ROM_SIZE;
  localparam int NUM_SEGS  = USED - 1;
  localparam int IDX_W     = (USED > 2) ? $clog2(USED) : 1;
  localparam int REM_W     = CODE_W + 1;
  localparam int QUOT_W    = FRAC_BITS + 1;
  localparam int SUM_W     = IDX_W + FRAC_BITS + 1;
  localparam int CNT_W     = $clog2(FRAC_BITS + 2);

  typedef struct packed {
    logic load;         // latch a new code, reset search bounds
    logic search_step;  // one binary search step
    logic div_init;     // set up the divider from the found segment
    logic div_step;     // one quotient bit
    logic out_load;     // capture the result into the output register
  } ctrl_cmd_t;

  typedef struct packed {
    logic oor;          // code outside the table span
    logic search_done;  // search bounds have met
    logic div_last;     // current divide step is the last one
  } dp_stat_t;

  // Thermistor codes, falling as temperature rises, 0..40 degrees.
  function automatic logic [CODE_W-1:0] rom_code(input logic [IDX_W-1:0] idx);
    logic [CODE_W-1:0] val;
    unique case (idx)
      6'd0:  val = 12'd3178;
      6'd1:  val = 12'd3139;
      6'd2:  val = 12'd3099;
      6'd3:  val = 12'd3059;
      6'd4:  val = 12'd3017;
      6'd5:  val = 12'd2975;
      6'd6:  val = 12'd2932;
      6'd7:  val = 12'd2888;
      6'd8:  val = 12'd2844;
      6'd9:  val = 12'd2799;
      6'd10: val = 12'd2754;
      6'd11: val = 12'd2708;
      6'd12: val = 12'd2662;
      6'd13: val = 12'd2615;
      6'd14: val = 12'd2569;
      6'd15: val = 12'd2521;
      6'd16: val = 12'd2474;
      6'd17: val = 12'd2427;
      6'd18: val = 12'd2379;
      6'd19: val = 12'd2331;
      6'd20: val = 12'd2284;
      6'd21: val = 12'd2236;
      6'd22: val = 12'd2189;
      6'd23: val = 12'd2141;
      6'd24: val = 12'd2094;
      6'd25: val = 12'd2048;
      6'd26: val = 12'd2001;
      6'd27: val = 12'd1955;
      6'd28: val = 12'd1909;
      6'd29: val = 12'd1864;
      6'd30: val = 12'd1819;
      6'd31: val = 12'd1775;
      6'd32: val = 12'd1731;
      6'd33: val = 12'd1688;
      6'd34: val = 12'd1645;
      6'd35: val = 12'd1603;
      6'd36: val = 12'd1562;
      6'd37: val = 12'd1522;
      6'd38: val = 12'd1482;
      6'd39: val = 12'd1442;
      6'd40: val = 12'd1404;
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

`default_nettype wire

### src/adcti_datapath.sv
// Datapath: code register, binary segment search, restoring divider, result register.
// Depends on adcti_pkg.
`timescale 1ns / 1ps
`default_nettype none

module adcti_datapath
  import adcti_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic [CODE_W-1:0] adc_code_i,
  input  wire ctrl_cmd_t         cmd_i,
  output dp_stat_t               stat_o,
  output logic [TEMP_W-1:0]      temperature_q8_o,
  output logic                   out_of_range_o
);

  logic [CODE_W-1:0] code_q, code_d;
  logic [IDX_W-1:0]  lo_q, lo_d, hi_q, hi_d;
  logic              oor_q, oor_d;
  logic [REM_W-1:0]  rem_q, rem_d;
  logic [CODE_W-1:0] span_q, span_d;
  logic [QUOT_W-1:0] quot_q, quot_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [TEMP_W-1:0] temp_q, temp_d;
  logic              oor_out_q, oor_out_d;

  logic [IDX_W:0]    mid_sum;
  logic [IDX_W-1:0]  mid;
  logic [IDX_W-1:0]  mid_next;
  logic [IDX_W-1:0]  lo_next;
  logic [CODE_W-1:0] seg_hi;
  logic [CODE_W-1:0] seg_lo;
  logic              ge;
  logic [REM_W-1:0]  rem_sub;
  logic [QUOT_W-1:0] frac;
  logic [SUM_W-1:0]  sum;

  always_comb begin
    mid_sum  = {1'b0, lo_q} + {1'b0, hi_q};
    mid      = mid_sum[IDX_W:1];
    mid_next = mid + IDX_W'(1);
    lo_next  = lo_q + IDX_W'(1);
    seg_hi   = rom_code(lo_q);
    seg_lo   = rom_code(lo_next);
    ge       = (rem_q >= {1'b0, span_q});
    rem_sub  = ge ? (rem_q - {1'b0, span_q}) : rem_q;
    frac     = (span_q == '0) ? '0 : quot_q;
    sum      = (SUM_W'(lo_q) << FRAC_BITS) + SUM_W'(frac);
  end

  always_comb begin
    code_d    = code_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    oor_d     = oor_q;
    rem_d     = rem_q;
    span_d    = span_q;
    quot_d    = quot_q;
    cnt_d     = cnt_q;
    temp_d    = temp_q;
    oor_out_d = oor_out_q;
    if (cmd_i.load) begin
      code_d = adc_code_i;
      lo_d   = '0;
      hi_d   = IDX_W'(NUM_SEGS - 1);
      oor_d  = (adc_code_i > rom_code('0)) ||
               (adc_code_i < rom_code(IDX_W'(USED - 1)));
    end
    if (cmd_i.search_step) begin
      // first segment whose lower entry is at or below the code
      if (rom_code(mid_next) <= code_q) begin
        hi_d = mid;
      end else begin
        lo_d = mid_next;
      end
    end
    if (cmd_i.div_init) begin
      span_d = seg_hi - seg_lo;
      rem_d  = {1'b0, seg_hi - code_q};
      quot_d = '0;
      cnt_d  = CNT_W'(FRAC_BITS + 1);
    end
    if (cmd_i.div_step) begin
      quot_d = {quot_q[QUOT_W-2:0], ge};
      rem_d  = {rem_sub[REM_W-2:0], 1'b0};
      cnt_d  = cnt_q - CNT_W'(1);
    end
    if (cmd_i.out_load) begin
      temp_d    = oor_q ? '0 : sum[TEMP_W-1:0];
      oor_out_d = oor_q;
    end
  end

  always_ff @(posedge clk_i) begin
    code_q    <= code_d;
    lo_q      <= lo_d;
    hi_q      <= hi_d;
    oor_q     <= oor_d;
    rem_q     <= rem_d;
    span_q    <= span_d;
    quot_q    <= quot_d;
    cnt_q     <= cnt_d;
    temp_q    <= temp_d;
    oor_out_q <= oor_out_d;
  end

  assign stat_o.oor         = oor_q;
  assign stat_o.search_done = (lo_q == hi_q);
  assign stat_o.div_last    = (cnt_q == CNT_W'(1));

  assign temperature_q8_o = temp_q;
  assign out_of_range_o   = oor_out_q;

endmodule

`default_nettype wire

### src/adcti_ctrl.sv
// Controller: sequences accept, search, divide and result hand-off; owns handshakes.
// Depends on adcti_pkg.
`timescale 1ns / 1ps
`default_nettype none

module adcti_ctrl
  import adcti_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  input  wire dp_stat_t stat_i,
  output ctrl_cmd_t cmd_o
);

  localparam logic [1:0] StIdle   = 2'd0;
  localparam logic [1:0] StSearch = 2'd1;
  localparam logic [1:0] StDivide = 2'd2;
  localparam logic [1:0] StFinish = 2'd3;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StSearch;
        end
      end
      StSearch: begin
        if (stat_i.oor) begin
          state_d = StFinish;
        end else if (stat_i.search_done) begin
          cmd_o.div_init = 1'b1;
          state_d        = StDivide;
        end else begin
          cmd_o.search_step = 1'b1;
        end
      end
      StDivide: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_last) begin
          state_d = StFinish;
        end
      end
      StFinish: begin
        if (slot_free) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

### src/adc_table_temperature_interp.sv
// Top level of the thermistor ADC code to temperature converter.
// Depends on adcti_pkg, adcti_ctrl and adcti_datapath.
//
//  channel | signals                                   | dir | payload
//  --------+-------------------------------------------+-----+---------------------------
//  in      | in_valid_i / in_ready_o                   | in  | adc_code_i[11:0]
//  out     | out_valid_o / out_ready_i                 | out | temperature_q8_o[13:0],
//          |                                           |     | out_of_range_o
//
// One request at a time; an in-range code goes through accept, a
// binary search of up to 6 steps over the 40 ROM segments, divider set-up, 9
// restoring divide steps (one quotient bit per cycle), result capture.
// Out-of-range codes skip search and divide and go straight to result capture.
// Reset (rst_ni low, async) returns the controller to idle and drops out_valid_o.
// The result sits in an output register; a new request is accepted while it waits,
// and a finished computation only stalls when the previous result is still untaken.
`timescale 1ns / 1ps
`default_nettype none

module adc_table_temperature_interp
  import adcti_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [CODE_W-1:0] adc_code_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [TEMP_W-1:0]      temperature_q8_o,
  output logic                   out_of_range_o
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  // sequencing and handshakes
  adcti_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // search, divide and output register
  adcti_datapath u_datapath (
    .clk_i            (clk_i),
    .adc_code_i       (adc_code_i),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .temperature_q8_o (temperature_q8_o),
    .out_of_range_o   (out_of_range_o)
  );

`ifndef SYNTHESIS
  // out-of-range results always carry a zero temperature
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_of_range_o |-> temperature_q8_o == '0)
    else $error("out-of-range result with nonzero temperature");

  // after accepting a request the block is not ready again in the cycle after
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request accepted twice in a row");

  // the controller never issues two commands in the same cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.load, cmd.search_step, cmd.div_init, cmd.div_step, cmd.out_load}))
    else $error("conflicting datapath commands");
`endif

endmodule

`default_nettype wire
